[rtl/core/mprq_pkg.sv]
// Package for the multilevel priority ready queue.
// Holds sizing constants, command and outcome codes, state encoding and payload types.
// Depends on nothing.
package mprq_pkg;

    localparam int NUM_LEVELS = 4;
    localparam int MAX_PROCS  = 32;

    localparam int ID_W    = 5;
    localparam int ID_SPACE = 1 << ID_W;
    localparam int CMD_W   = 2;
    localparam int PRIO_W  = 2;
    localparam int OUT_W   = 3;
    localparam int TICKS_W = 16;

    localparam int LVL_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int POS_W = $clog2(MAX_PROCS);
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    localparam logic [TICKS_W-1:0] QUANTUM_RESET = TICKS_W'(10);

    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KILL     = 2'd2;

    localparam logic [OUT_W-1:0] OUT_QUEUED     = 3'd0;
    localparam logic [OUT_W-1:0] OUT_ZOMBIFIED  = 3'd1;
    localparam logic [OUT_W-1:0] OUT_DISPATCHED = 3'd2;
    localparam logic [OUT_W-1:0] OUT_LEVEL_FULL = 3'd3;
    localparam logic [OUT_W-1:0] OUT_NONE_READY = 3'd4;
    localparam logic [OUT_W-1:0] OUT_KILL_MARKED = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ID_W-1:0]   proc_id;
        logic [PRIO_W-1:0] prio_level;
        logic              arrives_killed;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0]   outcome;
        logic [ID_W-1:0]    out_id;
        logic [TICKS_W-1:0] granted_ticks;
        logic               last;
    } t_out_item;

endpackage

[rtl/core/multilevel_priority_ready_queue.sv]
// Top level of the multilevel priority ready queue scheduler.
// Keeps one FIFO of process ids per priority level in a synchronous slot memory.
// Depends on mprq_pkg.
//
// Channel   Direction  Signals                              Transaction when
// input     in         i_in_valid, o_in_stall, i_in_data    i_in_valid && !o_in_stall
// output    out        o_out_valid, i_out_stall, o_out_data o_out_valid && !i_out_stall
// config    in         i_cfg_we, i_cfg_data                 i_cfg_we
//
// A transaction is executed in the cycle after it is taken. A dispatch reads the head of
// the lowest-numbered nonempty level from the slot memory and then checks its kill mark;
// a killed entry gives a zombified result and the dispatch goes on with the next one, and
// a dispatch that finds no entry ends with a none-ready result.
// Reset is synchronous and clears the level pointers, counts, kill marks and control.
// A stalled result holds the sequencer, which accepts no new transaction until it is idle again.
module multilevel_priority_ready_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mprq_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mprq_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_we,
    input  logic [mprq_pkg::TICKS_W-1:0]      i_cfg_data
);
    import mprq_pkg::*;

    t_state r_state, n_state;
    t_in_item r_item;
    logic [TICKS_W-1:0] r_quantum;

    logic [POS_W-1:0] r_head [NUM_LEVELS];
    logic [POS_W-1:0] r_tail [NUM_LEVELS];
    logic [CNT_W-1:0] r_count [NUM_LEVELS];
    logic [ID_SPACE-1:0] r_killed;

    logic [ID_W-1:0] r_slot_mem [NUM_LEVELS][MAX_PROCS];
    logic [ID_W-1:0] r_rd_data;

    logic r_out_valid;
    t_out_item r_out;

    logic out_free;
    logic in_take;
    logic [LVL_W-1:0] lvl;
    logic level_full;
    logic found;
    logic [LVL_W-1:0] sel;
    logic got_killed;

    logic emit;
    t_out_item emit_data;
    logic wr_en;
    logic rd_en;
    logic set_kill;
    logic clr_kill_item;
    logic clr_kill_got;

    assign out_free = !r_out_valid || !i_out_stall;
    assign in_take = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    assign lvl = (int'(r_item.prio_level) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
                                                          : LVL_W'(r_item.prio_level);
    assign level_full = (int'(r_count[lvl]) >= MAX_PROCS);
    assign got_killed = r_killed[r_rd_data];

    always_comb begin
        found = 1'b0;
        sel = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                found = 1'b1;
                sel = LVL_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_item.cmd == CMD_DISPATCH) begin
                    if (found) begin
                        n_state = ST_READ;
                    end else if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (r_item.cmd == CMD_SCHEDULE || r_item.cmd == CMD_KILL) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_state = got_killed ? ST_EXEC : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        emit = 1'b0;
        emit_data = '0;
        wr_en = 1'b0;
        rd_en = 1'b0;
        set_kill = 1'b0;
        clr_kill_item = 1'b0;
        clr_kill_got = 1'b0;
        case (r_state)
            ST_EXEC: begin
                emit_data.out_id = r_item.proc_id;
                emit_data.last = 1'b1;
                if (r_item.cmd == CMD_SCHEDULE) begin
                    emit = out_free;
                    if (r_item.arrives_killed) begin
                        emit_data.outcome = OUT_ZOMBIFIED;
                    end else if (level_full) begin
                        emit_data.outcome = OUT_LEVEL_FULL;
                    end else begin
                        emit_data.outcome = OUT_QUEUED;
                        wr_en = out_free;
                        clr_kill_item = out_free;
                    end
                end else if (r_item.cmd == CMD_KILL) begin
                    emit = out_free;
                    emit_data.outcome = OUT_KILL_MARKED;
                    set_kill = out_free;
                end else if (r_item.cmd == CMD_DISPATCH) begin
                    if (found) begin
                        rd_en = 1'b1;
                    end else begin
                        emit = out_free;
                        emit_data.outcome = OUT_NONE_READY;
                        emit_data.out_id = '0;
                    end
                end
            end
            ST_READ: begin
                emit = out_free;
                emit_data.out_id = r_rd_data;
                if (got_killed) begin
                    emit_data.outcome = OUT_ZOMBIFIED;
                    emit_data.last = 1'b0;
                    clr_kill_got = out_free;
                end else begin
                    emit_data.outcome = OUT_DISPATCHED;
                    emit_data.granted_ticks = r_quantum;
                    emit_data.last = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[lvl][r_tail[lvl]] <= r_item.proc_id;
        end
        if (rd_en) begin
            r_rd_data <= r_slot_mem[sel][r_head[sel]];
        end
        if (in_take) begin
            r_item <= i_in_data;
        end
        if (emit) begin
            r_out <= emit_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_quantum <= QUANTUM_RESET;
            r_killed <= '0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_quantum <= i_cfg_data;
            end
            if (set_kill) begin
                r_killed[r_item.proc_id] <= 1'b1;
            end
            if (clr_kill_item) begin
                r_killed[r_item.proc_id] <= 1'b0;
            end
            if (clr_kill_got) begin
                r_killed[r_rd_data] <= 1'b0;
            end
            if (wr_en) begin
                r_tail[lvl] <= (int'(r_tail[lvl]) == MAX_PROCS - 1) ? '0
                                                                     : r_tail[lvl] + 1'b1;
                r_count[lvl] <= r_count[lvl] + 1'b1;
            end
            if (rd_en) begin
                r_head[sel] <= (int'(r_head[sel]) == MAX_PROCS - 1) ? '0
                                                                     : r_head[sel] + 1'b1;
                r_count[sel] <= r_count[sel] - 1'b1;
            end
        end
    end

endmodule

[sim/tb_multilevel_priority_ready_queue.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the multilevel priority ready queue scheduler.
// Runs a directed table and random phases, predicts each result and checks it in order.
// Depends on mprq_pkg and multilevel_priority_ready_queue.
module tb_multilevel_priority_ready_queue;
    import mprq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_ITEMS   = 55;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item want;
    } t_row;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_we    = 1'b0;
    logic [TICKS_W-1:0]  i_cfg_data  = '0;

    // Scheduler state as predicted; integer and bit arrays start at their reset value of zero.
    logic [ID_W-1:0]     slot_ids [NUM_LEVELS][MAX_PROCS];
    int unsigned         lvl_head [NUM_LEVELS];
    int unsigned         lvl_tail [NUM_LEVELS];
    int unsigned         lvl_count [NUM_LEVELS];
    bit                  kill_marks [ID_SPACE];
    logic [TICKS_W-1:0]  quantum_now = QUANTUM_RESET;

    t_out_item           step_results[$];
    t_out_item           expected_outcomes[$];
    t_out_item           oldest_expected;
    t_row                directed_rows[$];
    int                  recent_ids[$];
    int                  mismatches = 0;
    int                  cycles = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;

    multilevel_priority_ready_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in_item make_item(logic [CMD_W-1:0] cmd, int id, int lvl, bit dead);
        t_in_item it;
        it.cmd            = cmd;
        it.proc_id        = ID_W'(id);
        it.prio_level     = PRIO_W'(lvl);
        it.arrives_killed = dead;
        return it;
    endfunction

    function automatic t_row mk_row(logic [CMD_W-1:0] cmd, int id, int lvl, bit dead,
                                    bit typed, logic [OUT_W-1:0] outc, int oid);
        t_row r;
        r.item               = make_item(cmd, id, lvl, dead);
        r.typed              = typed;
        r.want.outcome       = outc;
        r.want.out_id        = ID_W'(oid);
        r.want.granted_ticks = '0;
        r.want.last          = 1'b1;
        return r;
    endfunction

    task automatic add_result(logic [OUT_W-1:0] outc, logic [ID_W-1:0] id,
                              logic [TICKS_W-1:0] ticks);
        t_out_item r;
        r.outcome       = outc;
        r.out_id        = id;
        r.granted_ticks = ticks;
        r.last          = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic predict_outcomes(t_in_item it);
        int unsigned     lvl;
        int unsigned     n;
        logic [ID_W-1:0] got;
        bit              done;
        t_out_item       tail_res;
        step_results.delete();
        lvl = it.prio_level;
        if (lvl >= NUM_LEVELS) begin
            lvl = NUM_LEVELS - 1;
        end
        case (it.cmd)
            CMD_SCHEDULE: begin
                if (it.arrives_killed) begin
                    add_result(OUT_ZOMBIFIED, it.proc_id, '0);
                end else if (lvl_count[lvl] >= MAX_PROCS) begin
                    add_result(OUT_LEVEL_FULL, it.proc_id, '0);
                end else begin
                    slot_ids[lvl][lvl_tail[lvl]] = it.proc_id;
                    lvl_tail[lvl] = (lvl_tail[lvl] + 1) % MAX_PROCS;
                    lvl_count[lvl]++;
                    kill_marks[it.proc_id] = 1'b0;
                    add_result(OUT_QUEUED, it.proc_id, '0);
                end
            end
            CMD_KILL: begin
                kill_marks[it.proc_id] = 1'b1;
                add_result(OUT_KILL_MARKED, it.proc_id, '0);
            end
            CMD_DISPATCH: begin
                done = 1'b0;
                while (!done) begin
                    n = 0;
                    while (n < NUM_LEVELS && lvl_count[n] == 0) begin
                        n++;
                    end
                    if (n >= NUM_LEVELS) begin
                        add_result(OUT_NONE_READY, '0, '0);
                        done = 1'b1;
                    end else begin
                        got = slot_ids[n][lvl_head[n]];
                        lvl_head[n] = (lvl_head[n] + 1) % MAX_PROCS;
                        lvl_count[n]--;
                        if (kill_marks[got]) begin
                            kill_marks[got] = 1'b0;
                            add_result(OUT_ZOMBIFIED, got, '0);
                        end else begin
                            add_result(OUT_DISPATCHED, got, quantum_now);
                            done = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        if (step_results.size() > 0) begin
            tail_res      = step_results.pop_back();
            tail_res.last = 1'b1;
            step_results.push_back(tail_res);
        end
    endtask

    // Returns at the edge where the transaction is taken, with valid still high.
    task automatic send_item(t_in_item it, bit typed, t_out_item want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        predict_outcomes(it);
        if (typed) begin
            expected_outcomes.push_back(want);
        end else begin
            foreach (step_results[k]) begin
                expected_outcomes.push_back(step_results[k]);
            end
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_quantum(logic [TICKS_W-1:0] q);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= q;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        quantum_now  = q;
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int       r;
        it = make_item(CMD_W'($urandom), $urandom_range(ID_SPACE - 1), $urandom_range(3),
                       1'($urandom));
        r = $urandom_range(99);
        if (r < 40) begin
            it.cmd            = CMD_SCHEDULE;
            it.arrives_killed = ($urandom_range(9) == 0);
            if (!it.arrives_killed) begin
                recent_ids.push_back(it.proc_id);
                if (recent_ids.size() > 8) begin
                    void'(recent_ids.pop_front());
                end
            end
        end else if (r < 72) begin
            it.cmd = CMD_DISPATCH;
        end else if (r < 92) begin
            it.cmd = CMD_KILL;
            if (recent_ids.size() > 0 && $urandom_range(3) != 0) begin
                it.proc_id = ID_W'(recent_ids[$urandom_range(recent_ids.size() - 1)]);
            end
        end else if (r < 96) begin
            it.cmd = CMD_UNUSED;
        end
        return it;
    endfunction

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result: outcome %0d id %0d ticks %0d last %0b",
                             o_out_data.outcome, o_out_data.out_id,
                             o_out_data.granted_ticks, o_out_data.last);
                end
            end else begin
                oldest_expected = expected_outcomes.pop_front();
                if (o_out_data.outcome !== oldest_expected.outcome ||
                    o_out_data.out_id !== oldest_expected.out_id ||
                    o_out_data.granted_ticks !== oldest_expected.granted_ticks ||
                    o_out_data.last !== oldest_expected.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch: expected outcome %0d id %0d ticks %0d last %0b, %s",
                                 oldest_expected.outcome, oldest_expected.out_id,
                                 oldest_expected.granted_ticks, oldest_expected.last, "got");
                        $display("          actual   outcome %0d id %0d ticks %0d last %0b",
                                 o_out_data.outcome, o_out_data.out_id,
                                 o_out_data.granted_ticks, o_out_data.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [TICKS_W-1:0] phase_quanta [4];
        t_in_item           it;
        t_out_item          no_want;
        int                 done_items;
        int                 lvl_pick;
        int                 burst;
        int                 base_id;
        bit                 burst_done;

        no_want = '0;
        phase_quanta[0] = 16'hFFFF;
        phase_quanta[1] = 16'd1;
        phase_quanta[2] = 16'd0;
        phase_quanta[3] = TICKS_W'($urandom_range(65535, 1));

        directed_rows.push_back(mk_row(CMD_DISPATCH, 0, 0, 0, 1, OUT_NONE_READY, 0));
        directed_rows.push_back(mk_row(CMD_UNUSED, 31, 3, 1, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_KILL, 31, 3, 1, 1, OUT_KILL_MARKED, 31));
        directed_rows.push_back(mk_row(CMD_SCHEDULE, 31, 0, 1, 1, OUT_ZOMBIFIED, 31));
        directed_rows.push_back(mk_row(CMD_SCHEDULE, 0, 3, 0, 1, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_SCHEDULE, 31, 0, 0, 1, OUT_QUEUED, 31));
        directed_rows.push_back(mk_row(CMD_SCHEDULE, 5, 1, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_SCHEDULE, 5, 2, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_KILL, 5, 0, 0, 1, OUT_KILL_MARKED, 5));
        directed_rows.push_back(mk_row(CMD_DISPATCH, 31, 3, 1, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_DISPATCH, 0, 0, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_DISPATCH, 0, 0, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_DISPATCH, 0, 0, 0, 1, OUT_NONE_READY, 0));
        directed_rows.push_back(mk_row(CMD_SCHEDULE, 7, 2, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_SCHEDULE, 8, 2, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_KILL, 7, 1, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_KILL, 8, 1, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_DISPATCH, 0, 0, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_KILL, 0, 0, 0, 1, OUT_KILL_MARKED, 0));
        directed_rows.push_back(mk_row(CMD_SCHEDULE, 0, 3, 0, 0, OUT_QUEUED, 0));
        directed_rows.push_back(mk_row(CMD_DISPATCH, 0, 0, 0, 0, OUT_QUEUED, 0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) begin
            send_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
        end

        for (int phase = 0; phase < 4; phase++) begin
            wait_drained();
            write_quantum(phase_quanta[phase]);
            send_idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 20 : 0;
            recv_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 20 : 0;
            done_items = 0;
            burst_done = 1'b0;
            while (done_items < PHASE_ITEMS) begin
                if (!burst_done && done_items >= PHASE_ITEMS / 2) begin
                    burst_done = 1'b1;
                    wait_drained();
                    if (phase == 2) begin
                        lvl_pick = $urandom_range(3);
                        repeat (MAX_PROCS + 2) begin
                            send_item(make_item(CMD_SCHEDULE, $urandom_range(ID_SPACE - 1),
                                                lvl_pick, 0), 0, no_want);
                        end
                    end
                    // A run of killed entries, so that one dispatch skips many of them.
                    burst   = $urandom_range(12, 4);
                    base_id = $urandom_range(ID_SPACE - 1);
                    for (int b = 0; b < burst; b++) begin
                        send_item(make_item(CMD_SCHEDULE, (base_id + b) % ID_SPACE,
                                            $urandom_range(1), 0), 0, no_want);
                    end
                    for (int b = 0; b < burst; b++) begin
                        send_item(make_item(CMD_KILL, (base_id + b) % ID_SPACE,
                                            $urandom_range(3), 1'($urandom)), 0, no_want);
                    end
                    send_item(make_item(CMD_DISPATCH, 0, 0, 0), 0, no_want);
                end
                it = random_item();
                if (it.cmd != CMD_UNUSED) begin
                    done_items++;
                end
                send_item(it, 0, no_want);
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
